[rtl/tbp_pkg.sv]
package tbp_pkg;

    // Address width of a branch instruction
    localparam int PC_W = 32;

    // 2-bit saturating counter codes
    localparam logic [1:0] CTR_MIN  = 2'd0;
    localparam logic [1:0] CTR_INIT = 2'd1;
    localparam logic [1:0] CTR_MAX  = 2'd3;

    // Entries in the queue between front and back
    localparam logic [1:0] Q_DEPTH = 2'd2;

    typedef enum logic {
        OP_PREDICT = 1'b0,
        OP_TRAIN   = 1'b1
    } t_op;

    // Command payload as it arrives on the port
    typedef struct packed {
        t_op              operation;
        logic [PC_W-1:0]  pc;
        logic             outcome;
    } t_cmd;

    // Result payload
    typedef struct packed {
        logic predict_taken;
        logic used_global;
    } t_result;

    // Decoded item held in the queue
    typedef struct packed {
        logic             train;
        logic [PC_W-1:0]  pc;
        logic             outcome;
    } t_item;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Back-end status seen by the front
    typedef struct packed {
        logic clearing;
    } t_back_stat;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } t_back_state;

    // Move a 2-bit counter one step, saturating at both ends
    function automatic logic [1:0] sat_move(input logic [1:0] v, input logic up);
        logic [1:0] res;
        if (up) begin
            res = (v == CTR_MAX) ? CTR_MAX : v + 2'd1;
        end else begin
            res = (v == CTR_MIN) ? CTR_MIN : v - 2'd1;
        end
        return res;
    endfunction

endpackage

[rtl/tbp_front.sv]
module tbp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  tbp_pkg::t_cmd        i_cmd,
    output logic                 o_busy,
    input  tbp_pkg::t_back_stat  i_back_stat,
    input  tbp_pkg::t_q_stat     i_q_stat,
    output logic                 o_push,
    output tbp_pkg::t_item       o_item
);

    logic            r_valid;
    tbp_pkg::t_item  r_item;
    logic            accept;

    // Hold off while the tables clear or while the holding stage cannot drain
    assign o_busy = i_back_stat.clearing | (r_valid & i_q_stat.full);
    assign accept = i_start & ~o_busy;
    assign o_push = r_valid & ~i_q_stat.full;
    assign o_item = r_item;

    // Holding stage valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // Decode the command; outcome means nothing for a predict
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.train   <= (i_cmd.operation == tbp_pkg::OP_TRAIN);
            r_item.pc      <= i_cmd.pc;
            r_item.outcome <= (i_cmd.operation == tbp_pkg::OP_TRAIN) & i_cmd.outcome;
        end
    end

endmodule

[rtl/tbp_queue.sv]
module tbp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tbp_pkg::t_item    i_item,
    input  logic              i_pop,
    output tbp_pkg::t_item    o_item,
    output tbp_pkg::t_q_stat  o_stat
);

    tbp_pkg::t_item  r_data [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;

    assign o_item       = r_data[r_rd_ptr];
    assign o_stat.full  = (r_count == tbp_pkg::Q_DEPTH);
    assign o_stat.empty = (r_count == 2'd0);

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_item;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_stat.full || i_pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

[rtl/tbp_back.sv]
module tbp_back #(
    parameter int GLOBAL_BITS  = 16,
    parameter int LOCAL_BITS   = 16,
    parameter int CHOOSER_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tbp_pkg::t_q_stat     i_q_stat,
    input  tbp_pkg::t_item       i_q_item,
    output logic                 o_pop,
    output tbp_pkg::t_back_stat  o_stat,
    output logic                 o_valid,
    output tbp_pkg::t_result     o_result
);

    localparam int HIST_BITS = (GLOBAL_BITS > CHOOSER_BITS) ? GLOBAL_BITS : CHOOSER_BITS;
    localparam int GL_MAX    = (GLOBAL_BITS > LOCAL_BITS) ? GLOBAL_BITS : LOCAL_BITS;
    localparam int CLR_BITS  = (GL_MAX > CHOOSER_BITS) ? GL_MAX : CHOOSER_BITS;
    localparam int G_DEPTH   = 1 << GLOBAL_BITS;
    localparam int L_DEPTH   = 1 << LOCAL_BITS;
    localparam int C_DEPTH   = 1 << CHOOSER_BITS;

    tbp_pkg::t_back_state     r_state;
    tbp_pkg::t_back_state     n_state;
    logic [CLR_BITS-1:0]      r_clr;
    logic [HIST_BITS-1:0]     r_hist;
    tbp_pkg::t_item           r_item;

    logic [1:0]               r_g_mem [G_DEPTH];
    logic [1:0]               r_l_mem [L_DEPTH];
    logic [1:0]               r_c_mem [C_DEPTH];
    logic [1:0]               r_g_rd;
    logic [1:0]               r_l_rd;
    logic [1:0]               r_c_rd;

    logic [GLOBAL_BITS-1:0]   r_gi;
    logic [LOCAL_BITS-1:0]    r_li;
    logic [CHOOSER_BITS-1:0]  r_ci;

    logic                     r_out_valid;
    tbp_pkg::t_result         r_out;

    logic                     pop;
    logic                     rd_en;
    logic                     clr_we;
    logic                     upd_we;
    logic                     g_pred;
    logic                     l_pred;
    logic                     use_g;
    logic                     g_ok;
    logic                     l_ok;
    logic [1:0]               g_wdata;
    logic [1:0]               l_wdata;
    logic [1:0]               c_wdata;

    assign o_pop           = pop;
    assign o_stat.clearing = (r_state == tbp_pkg::ST_CLEAR);
    assign o_valid         = r_out_valid;
    assign o_result        = r_out;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbp_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and strobes
    always_comb begin
        n_state = r_state;
        pop     = 1'b0;
        rd_en   = 1'b0;
        clr_we  = 1'b0;
        upd_we  = 1'b0;
        case (r_state)
            tbp_pkg::ST_CLEAR: begin
                clr_we = 1'b1;
                if (r_clr == {CLR_BITS{1'b1}}) begin
                    n_state = tbp_pkg::ST_IDLE;
                end
            end
            tbp_pkg::ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    pop     = 1'b1;
                    n_state = tbp_pkg::ST_READ;
                end
            end
            tbp_pkg::ST_READ: begin
                rd_en   = 1'b1;
                n_state = tbp_pkg::ST_EVAL;
            end
            tbp_pkg::ST_EVAL: begin
                upd_we = r_item.train;
                if (!i_q_stat.empty) begin
                    pop     = 1'b1;
                    n_state = tbp_pkg::ST_READ;
                end else begin
                    n_state = tbp_pkg::ST_IDLE;
                end
            end
            default: n_state = tbp_pkg::ST_CLEAR;
        endcase
    end

    // Clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (clr_we) begin
            r_clr <= r_clr + {{(CLR_BITS-1){1'b0}}, 1'b1};
        end
    end

    // Global history; newest outcome enters at bit 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (upd_we) begin
            r_hist <= {r_hist[HIST_BITS-2:0], r_item.outcome};
        end
    end

    // Item taken from the queue
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_item <= i_q_item;
        end
    end

    // Table indexes, latched with the read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_gi <= r_item.pc[GLOBAL_BITS-1:0] ^ r_hist[GLOBAL_BITS-1:0];
            r_li <= r_item.pc[LOCAL_BITS-1:0];
            r_ci <= r_item.pc[CHOOSER_BITS-1:0] ^ r_hist[CHOOSER_BITS-1:0];
        end
    end

    // Predictions from pre-update counters
    assign g_pred = r_g_rd[1];
    assign l_pred = r_l_rd[1];
    assign use_g  = r_c_rd[1];
    assign g_ok   = (g_pred == r_item.outcome);
    assign l_ok   = (l_pred == r_item.outcome);

    // Write data: reset value during the sweep, updated counter otherwise
    always_comb begin
        if (clr_we) begin
            g_wdata = tbp_pkg::CTR_INIT;
            l_wdata = tbp_pkg::CTR_INIT;
            c_wdata = tbp_pkg::CTR_INIT;
        end else begin
            g_wdata = tbp_pkg::sat_move(r_g_rd, r_item.outcome);
            l_wdata = tbp_pkg::sat_move(r_l_rd, r_item.outcome);
            if (g_ok && !l_ok) begin
                c_wdata = tbp_pkg::sat_move(r_c_rd, 1'b1);
            end else if (l_ok && !g_ok) begin
                c_wdata = tbp_pkg::sat_move(r_c_rd, 1'b0);
            end else begin
                c_wdata = r_c_rd;
            end
        end
    end

    // Gshare counter table
    always_ff @(posedge i_clk) begin
        if (clr_we) begin
            r_g_mem[r_clr[GLOBAL_BITS-1:0]] <= g_wdata;
        end else if (upd_we) begin
            r_g_mem[r_gi] <= g_wdata;
        end
        if (rd_en) begin
            r_g_rd <= r_g_mem[r_item.pc[GLOBAL_BITS-1:0] ^ r_hist[GLOBAL_BITS-1:0]];
        end
    end

    // Per-pc counter table
    always_ff @(posedge i_clk) begin
        if (clr_we) begin
            r_l_mem[r_clr[LOCAL_BITS-1:0]] <= l_wdata;
        end else if (upd_we) begin
            r_l_mem[r_li] <= l_wdata;
        end
        if (rd_en) begin
            r_l_rd <= r_l_mem[r_item.pc[LOCAL_BITS-1:0]];
        end
    end

    // Chooser table
    always_ff @(posedge i_clk) begin
        if (clr_we) begin
            r_c_mem[r_clr[CHOOSER_BITS-1:0]] <= c_wdata;
        end else if (upd_we) begin
            r_c_mem[r_ci] <= c_wdata;
        end
        if (rd_en) begin
            r_c_rd <= r_c_mem[r_item.pc[CHOOSER_BITS-1:0] ^ r_hist[CHOOSER_BITS-1:0]];
        end
    end

    // Result register, one strobe per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (r_state == tbp_pkg::ST_EVAL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tbp_pkg::ST_EVAL) begin
            r_out.predict_taken <= use_g ? g_pred : l_pred;
            r_out.used_global   <= use_g;
        end
    end

`ifndef ASSERT_OFF
    a_out_after_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $past(r_state == tbp_pkg::ST_EVAL))
        else $error("result strobe without an evaluated item");

    a_hist_hold_predict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tbp_pkg::ST_EVAL && !r_item.train) |=> $stable(r_hist))
        else $error("history changed on a predict");

    a_no_pop_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tbp_pkg::ST_CLEAR) |-> (!pop && !upd_we))
        else $error("item handled during table clear");

    a_read_then_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tbp_pkg::ST_READ) |=> (r_state == tbp_pkg::ST_EVAL))
        else $error("read not followed by evaluation");
`endif

endmodule

[rtl/tournament_branch_predictor.sv]
// Tournament branch predictor: gshare, per-pc bimodal and a chooser table.
// Command channel: i_cmd (operation, pc, outcome) is transferred at a rising
// edge where start is high and busy is low. A predict reads the tables only;
// a train also updates the chooser, both counters and the global history.
// Result channel: o_result (predict_taken, used_global) is shown for exactly
// one cycle with o_valid high; the receiver cannot stall it, so it must take
// every result on that cycle. Results come out in command order.
// Path: holding stage, queue, the back end's item register, its read and
// evaluate states, then the result register. The back end reads the
// single-port counter tables in one pass and evaluates and updates them in
// a second, popping another queued item during it. Commands are buffered in
// a holding stage and a two-entry queue; busy rises when both are full.
// Reset: synchronous, active low. After reset a clearing sweep writes the
// weakly-not-taken value into every counter, one entry a cycle, covering
// 2**max(GLOBAL_BITS, LOCAL_BITS, CHOOSER_BITS) entries (65536 by default);
// busy stays high during the sweep. History resets to zero.
module tournament_branch_predictor #(
    parameter int GLOBAL_BITS  = 16,
    parameter int LOCAL_BITS   = 16,
    parameter int CHOOSER_BITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  tbp_pkg::t_cmd     i_cmd,
    output logic              busy,
    output logic              o_valid,
    output tbp_pkg::t_result  o_result
);

    tbp_pkg::t_back_stat  back_stat;
    tbp_pkg::t_q_stat     q_stat;
    tbp_pkg::t_item       push_item;
    tbp_pkg::t_item       head_item;
    logic                 push;
    logic                 pop;

    tbp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (i_cmd),
        .o_busy      (busy),
        .i_back_stat (back_stat),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_item      (push_item)
    );

    tbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_stat  (q_stat)
    );

    tbp_back #(
        .GLOBAL_BITS  (GLOBAL_BITS),
        .LOCAL_BITS   (LOCAL_BITS),
        .CHOOSER_BITS (CHOOSER_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_q_item (head_item),
        .o_pop    (pop),
        .o_stat   (back_stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

[dv/tournament_branch_predictor_tb.sv]
`timescale 1ns / 1ps

module tournament_branch_predictor_tb;

    // Table geometry of the instance under test
    localparam int G_BITS = 16;
    localparam int L_BITS = 16;
    localparam int C_BITS = 10;
    localparam int HIST_W = (G_BITS > C_BITS) ? G_BITS : C_BITS;
    localparam int N_HOT = 8;
    // Clearing sweep plus ~1400 items at worst-case gaps, taken several times over
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_PRINTS = 100;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    tbp_pkg::t_cmd i_cmd = '0;
    logic busy;
    logic o_valid;
    tbp_pkg::t_result o_result;

    // Shadow copy of the predictor state
    logic [1:0] gshare_ctr [2**G_BITS];
    logic [1:0] bimodal_ctr [2**L_BITS];
    logic [1:0] chooser_ctr [2**C_BITS];
    logic [HIST_W-1:0] ghist;

    // Predictions still waiting for their result transfer
    tbp_pkg::t_result predicted_dirs [$];

    // Branch streams that repeat, so the tables actually learn
    logic [tbp_pkg::PC_W-1:0] hot_pc [N_HOT];
    int unsigned hot_seen [N_HOT];

    int idle_pct = 0;
    int err_count = 0;
    int cycle_count = 0;
    int n_train = 0;
    int n_predict = 0;
    int n_checked = 0;
    int n_gshare_sel = 0;

    tournament_branch_predictor #(
        .GLOBAL_BITS  (G_BITS),
        .LOCAL_BITS   (L_BITS),
        .CHOOSER_BITS (C_BITS)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, predicted_dirs.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
    endtask

    // One saturating step of a 2-bit counter
    function automatic logic [1:0] ctr_step(input logic [1:0] v, input logic up);
        logic [1:0] nv;
        if (up) begin
            nv = (v == tbp_pkg::CTR_MAX) ? tbp_pkg::CTR_MAX : v + 2'd1;
        end else begin
            nv = (v == tbp_pkg::CTR_MIN) ? tbp_pkg::CTR_MIN : v - 2'd1;
        end
        return nv;
    endfunction

    // Prediction from pre-update state; a train then updates the shadow tables
    function automatic tbp_pkg::t_result shadow_step(input tbp_pkg::t_cmd c);
        logic [G_BITS-1:0] gi;
        logic [L_BITS-1:0] li;
        logic [C_BITS-1:0] ci;
        logic g_taken;
        logic l_taken;
        logic use_g;
        tbp_pkg::t_result r;
        gi = c.pc[G_BITS-1:0] ^ ghist[G_BITS-1:0];
        li = c.pc[L_BITS-1:0];
        ci = c.pc[C_BITS-1:0] ^ ghist[C_BITS-1:0];
        g_taken = gshare_ctr[gi][1];
        l_taken = bimodal_ctr[li][1];
        use_g = chooser_ctr[ci][1];
        r.predict_taken = use_g ? g_taken : l_taken;
        r.used_global = use_g;
        if (c.operation == tbp_pkg::OP_TRAIN) begin
            // chooser leans toward whichever component alone was right
            if (g_taken == c.outcome && l_taken != c.outcome) begin
                chooser_ctr[ci] = ctr_step(chooser_ctr[ci], 1'b1);
            end else if (l_taken == c.outcome && g_taken != c.outcome) begin
                chooser_ctr[ci] = ctr_step(chooser_ctr[ci], 1'b0);
            end
            bimodal_ctr[li] = ctr_step(bimodal_ctr[li], c.outcome);
            gshare_ctr[gi] = ctr_step(gshare_ctr[gi], c.outcome);
            ghist = {ghist[HIST_W-2:0], c.outcome};
        end
        return r;
    endfunction

    function automatic tbp_pkg::t_cmd mk_cmd(input tbp_pkg::t_op op,
                                             input logic [tbp_pkg::PC_W-1:0] pc,
                                             input logic outcome);
        tbp_pkg::t_cmd c;
        c.operation = op;
        c.pc = pc;
        c.outcome = outcome;
        return c;
    endfunction

    // pc whose gshare/chooser index lands on the given slot under current history
    function automatic logic [tbp_pkg::PC_W-1:0] aligned_pc(
        input logic [tbp_pkg::PC_W-1:0] base);
        return base ^ {{(tbp_pkg::PC_W-HIST_W){1'b0}}, ghist};
    endfunction

    // Present one command, hold it until transferred, then maybe go idle
    task automatic send_cmd(input tbp_pkg::t_cmd c);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        predicted_dirs.push_back(shadow_step(c));
        if (c.operation == tbp_pkg::OP_TRAIN) n_train++;
        else n_predict++;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            // junk on the bus while start is low must be ignored
            i_cmd <= mk_cmd(tbp_pkg::t_op'($urandom_range(1)), $urandom,
                            1'($urandom_range(1)));
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (predicted_dirs.size() != 0) @(posedge i_clk);
    endtask

    // Result checker: the receiver cannot stall, take every strobe
    always @(posedge i_clk) begin : result_check
        tbp_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (predicted_dirs.size() == 0) begin
                report_mismatch($sformatf("result %b with no command outstanding", o_result));
            end else begin
                want = predicted_dirs.pop_front();
                n_checked++;
                if (o_result.used_global) n_gshare_sel++;
                if (o_result.predict_taken !== want.predict_taken) begin
                    report_mismatch($sformatf("result %0d predict_taken got %b want %b",
                                              n_checked, o_result.predict_taken,
                                              want.predict_taken));
                end
                if (o_result.used_global !== want.used_global) begin
                    report_mismatch($sformatf("result %0d used_global got %b want %b",
                                              n_checked, o_result.used_global,
                                              want.used_global));
                end
            end
        end
    end

    task automatic run_reset();
        foreach (gshare_ctr[i]) gshare_ctr[i] = tbp_pkg::CTR_INIT;
        foreach (bimodal_ctr[i]) bimodal_ctr[i] = tbp_pkg::CTR_INIT;
        foreach (chooser_ctr[i]) chooser_ctr[i] = tbp_pkg::CTR_INIT;
        ghist = '0;
        for (int i = 0; i < N_HOT; i++) begin
            hot_pc[i] = $urandom;
            hot_seen[i] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Address and direction extremes; outcome is don't-care on predict
    task automatic test_extreme_fields();
        send_cmd(mk_cmd(tbp_pkg::OP_PREDICT, 32'h0000_0000, 1'b1));
        send_cmd(mk_cmd(tbp_pkg::OP_PREDICT, 32'hFFFF_FFFF, 1'b0));
        send_cmd(mk_cmd(tbp_pkg::OP_TRAIN, 32'hFFFF_FFFF, 1'b1));
        send_cmd(mk_cmd(tbp_pkg::OP_TRAIN, 32'h0000_0000, 1'b0));
    endtask

    // Counters pinned at both rails, predict-only leaves tables alone,
    // chooser moves only when exactly one component is right
    task automatic test_counter_saturation();
        logic [tbp_pkg::PC_W-1:0] pc_a;
        logic [tbp_pkg::PC_W-1:0] pc_z;
        logic [tbp_pkg::PC_W-1:0] pc_b;
        pc_a = 32'h8000_1234;
        pc_z = 32'h0000_5A5A;
        pc_b = 32'h4000_BEEF;
        // per-pc counter down to the floor, both components right
        repeat (3) send_cmd(mk_cmd(tbp_pkg::OP_TRAIN, pc_a, 1'b0));
        // gshare counter down to the floor on one slot
        repeat (3) send_cmd(mk_cmd(tbp_pkg::OP_TRAIN, aligned_pc(pc_z), 1'b0));
        repeat (2) send_cmd(mk_cmd(tbp_pkg::OP_PREDICT, pc_a, 1'b1));
        // per-pc counter up to the ceiling; both wrong first, then per-pc alone right
        repeat (4) send_cmd(mk_cmd(tbp_pkg::OP_TRAIN, pc_a, 1'b1));
        // gshare slot climbs and wins the chooser while per-pc entries stay wrong
        repeat (4) send_cmd(mk_cmd(tbp_pkg::OP_TRAIN, aligned_pc(pc_b), 1'b1));
        send_cmd(mk_cmd(tbp_pkg::OP_PREDICT, aligned_pc(pc_b), 1'b0));
    endtask

    // Branch-like traffic: mostly repeating streams, some history-aligned, rest noise
    task automatic test_random_traffic(input int n_items, input int pct);
        tbp_pkg::t_cmd c;
        int k;
        int slot;
        idle_pct = pct;
        for (int i = 0; i < n_items; i++) begin
            k = $urandom_range(99);
            slot = $urandom_range(N_HOT - 1);
            c.operation = ($urandom_range(99) < 75) ? tbp_pkg::OP_TRAIN : tbp_pkg::OP_PREDICT;
            if (k < 65) begin
                c.pc = (k < 50) ? hot_pc[slot] : aligned_pc(hot_pc[slot]);
                // each stream follows one of four direction patterns, picked by its slot
                case (slot % 4)
                    0: c.outcome = ($urandom_range(9) != 0);
                    1: c.outcome = ($urandom_range(9) == 0);
                    2: c.outcome = hot_seen[slot][0];
                    default: c.outcome = (hot_seen[slot] % 3) != 2;
                endcase
                if (c.operation == tbp_pkg::OP_TRAIN) hot_seen[slot]++;
            end else begin
                c.pc = $urandom;
                c.outcome = 1'($urandom_range(1));
            end
            send_cmd(c);
        end
        idle_pct = 0;
    endtask

    // Sender holds off until every outstanding result is back, then resumes
    task automatic test_pause_until_drained();
        test_random_traffic(60, 0);
        wait_drained();
        repeat ($urandom_range(3, 12)) @(posedge i_clk);
        test_random_traffic(300, 0);
    endtask

    initial begin
        run_reset();
        test_extreme_fields();
        test_counter_saturation();
        test_random_traffic(350, 0);
        test_random_traffic(300, 80);
        test_random_traffic(400, 7);
        test_pause_until_drained();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (predicted_dirs.size() != 0) begin
            report_mismatch($sformatf("%0d predictions never came back", predicted_dirs.size()));
        end
        $display("Run covered %0d train and %0d predict commands, %0d results checked",
                 n_train, n_predict, n_checked);
        $display("Chooser picked gshare on %0d results; %0d mismatches",
                 n_gshare_sel, err_count);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/tbp_pkg.sv
rtl/tbp_front.sv
rtl/tbp_queue.sv
rtl/tbp_back.sv
rtl/tournament_branch_predictor.sv
dv/tournament_branch_predictor_tb.sv
